>>> rtl/dtcw_pkg.sv
package dtcw_pkg;

  localparam int YEAR_W = 12;
  localparam int FIELD_W = 8;
  localparam int OFFSET_W = 7;
  localparam int WDAY_W = 3;

  localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 12'd2000;
  localparam int YEAR_SPAN_DEF = 127;

  // formula year runs up to 4095 + 400, so one more bit than the input year
  localparam int YS_W = YEAR_W + 1;
  localparam int GREG_CYCLE = 400;

  // floor(y / 100) == (y * 5243) >> 19 for every y below 8192
  localparam int RECIP100 = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W = 25;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  localparam int SUM_W = 13;
  localparam int LEN_W = 5;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } stamp_t;

  typedef struct packed {
    logic                date_ok;
    logic                time_ok;
    logic [OFFSET_W-1:0] year_offset;
    logic [WDAY_W-1:0]   weekday;
  } check_t;

  localparam logic [FIELD_W-1:0] MONTH_FEB = 8'd2;
  localparam logic [FIELD_W-1:0] MONTH_DEC = 8'd12;
  localparam logic [FIELD_W-1:0] HOURS_PER_DAY = 8'd24;
  localparam logic [FIELD_W-1:0] MINUTES_PER_HOUR = 8'd60;
  localparam logic [WDAY_W-1:0] SUNDAY = 3'd7;
  localparam logic [WDAY_W-1:0] NO_WEEKDAY = 3'd0;

  // days in the month, February without the leap day
  function automatic logic [LEN_W-1:0] month_len(input logic [3:0] mo);
    logic [LEN_W-1:0] len;
    unique case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * m) / 12 with m counted from March = 1, January and February as 11 and 12
  function automatic logic [LEN_W-1:0] month_term(input logic [3:0] mo);
    logic [LEN_W-1:0] t;
    unique case (mo)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/dtcw_pipe.sv
module dtcw_pipe #(
  parameter int YEAR_SPAN = dtcw_pkg::YEAR_SPAN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  dtcw_pkg::stamp_t               stamp,
  input  logic [dtcw_pkg::YEAR_W-1:0]    base_year,
  output logic                           done,
  output dtcw_pkg::check_t               check
);
  import dtcw_pkg::*;

  localparam int CMP_W = YEAR_W + 1;
  localparam logic [CMP_W-1:0] SPAN = CMP_W'(YEAR_SPAN);

  // stage 1: range checks, table lookups, reciprocal products
  logic                v1;
  logic                time_ok1, year_ok1, month_ok1, feb1;
  logic [LEN_W-1:0]    len1, tm1;
  logic [FIELD_W-1:0]  day1;
  logic [YEAR_W-1:0]   year1;
  logic [YS_W-1:0]     ys1;
  logic [PROD_W-1:0]   py1, ps1;
  logic [OFFSET_W-1:0] off1;

  logic            early;
  logic [YS_W-1:0] ys;
  logic [YEAR_W-1:0] diff;

  assign early = (stamp.month <= MONTH_FEB);
  assign ys = YS_W'(stamp.year) + YS_W'(GREG_CYCLE) - YS_W'(early);
  assign diff = stamp.year - base_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    time_ok1  <= (stamp.hour < HOURS_PER_DAY) && (stamp.minute < MINUTES_PER_HOUR) &&
                 (stamp.second < MINUTES_PER_HOUR);
    year_ok1  <= (stamp.year >= base_year) &&
                 (CMP_W'(stamp.year) <= CMP_W'(base_year) + SPAN);
    month_ok1 <= (stamp.month != '0) && (stamp.month <= MONTH_DEC);
    feb1      <= (stamp.month == MONTH_FEB);
    len1      <= month_len(stamp.month[3:0]);
    tm1       <= month_term(stamp.month[3:0]);
    day1      <= stamp.day;
    year1     <= stamp.year;
    ys1       <= ys;
    py1       <= PROD_W'(stamp.year) * PROD_W'(RECIP100);
    ps1       <= PROD_W'(ys) * PROD_W'(RECIP100);
    off1      <= diff[OFFSET_W-1:0];
  end

  // stage 2: leap year, day range, weekday sum
  logic                v2;
  logic                date_ok2, time_ok2, month_ok2;
  logic [OFFSET_W-1:0] off2;
  logic [SUM_W-1:0]    sum2;

  logic [QUOT_W-1:0] qy, qs;
  logic              cent, leap, date_ok;
  logic [LEN_W-1:0]  len;
  logic [SUM_W-1:0]  sum;

  assign qy = py1[PROD_W-1:RECIP_SHIFT];
  assign qs = ps1[PROD_W-1:RECIP_SHIFT];
  assign cent = (year1 == YEAR_W'(qy) * YEAR_W'(100));
  // divisible by 400: century year whose century count is a multiple of four
  assign leap = (year1[1:0] == 2'b00) && (!cent || (qy[1:0] == 2'b00));
  assign len = len1 + LEN_W'(feb1 && leap);
  assign date_ok = year_ok1 && month_ok1 && (day1 != '0) && (day1 <= FIELD_W'(len));
  assign sum = SUM_W'(day1) + SUM_W'(ys1) + SUM_W'(ys1 >> 2) - SUM_W'(qs) +
               SUM_W'(qs >> 2) + SUM_W'(tm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    date_ok2  <= date_ok;
    time_ok2  <= time_ok1;
    month_ok2 <= month_ok1;
    off2      <= date_ok ? off1 : '0;
    sum2      <= sum;
  end

  // stage 3: sum mod 7 by folding octal digits (8 is 1 mod 7)
  logic [4:0]        fold1;
  logic [3:0]        fold2;
  logic [WDAY_W-1:0] wmod, wday;

  assign fold1 = 5'(sum2[2:0]) + 5'(sum2[5:3]) + 5'(sum2[8:6]) + 5'(sum2[11:9]) +
                 5'(sum2[12]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign wmod = (fold2 >= 4'd7) ? WDAY_W'(fold2 - 4'd7) : fold2[WDAY_W-1:0];
  assign wday = !month_ok2 ? NO_WEEKDAY : ((wmod == '0) ? SUNDAY : wmod);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    check.date_ok     <= date_ok2;
    check.time_ok     <= time_ok2;
    check.year_offset <= off2;
    check.weekday     <= wday;
  end

endmodule

>>> rtl/date_time_check_weekday_top.sv
// Date and time check with weekday: each accepted word yields one done strobe.
// Throughput one word per cycle; the three pipeline stages each register their
// results, so busy stays low and a new word may start every cycle.
// The receiver cannot stall; each result is shown for one cycle with done.
// Synchronous reset clears the stage valid bits and loads base_year with 2000.
module date_time_check_weekday_top #(
  parameter int YEAR_SPAN = dtcw_pkg::YEAR_SPAN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  dtcw_pkg::stamp_t            stamp,
  output logic                        done,
  output dtcw_pkg::check_t            check,
  input  logic                        cfg_we,
  input  logic [dtcw_pkg::YEAR_W-1:0] cfg_wdata
);
  import dtcw_pkg::*;

  logic [YEAR_W-1:0] base_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
    end else if (cfg_we) begin
      base_year <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  dtcw_pipe #(
    .YEAR_SPAN(YEAR_SPAN)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .stamp    (stamp),
    .base_year(base_year),
    .done     (done),
    .check    (check)
  );

endmodule

>>> bench/date_time_check_weekday_top_test.sv
`timescale 1ns / 100ps

module date_time_check_weekday_top_test;
  import dtcw_pkg::*;

  localparam int SPAN = YEAR_SPAN_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 200;

  typedef enum logic [1:0] {OP_STAMP, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t          kind;
    stamp_t            stamp;
    logic [YEAR_W-1:0] value;
  } op_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  stamp_t            stamp_in = '0;
  logic              done;
  check_t            check;
  logic              cfg_we = 1'b0;
  logic [YEAR_W-1:0] cfg_wdata = '0;

  op_t               pending_ops[$];
  check_t            due_checks[$];
  logic [YEAR_W-1:0] model_base;
  int                errors = 0;
  int                cycles = 0;
  int                gap_cnt = 0;
  int                burst_left = 0;
  logic              step_start;
  logic              step_we;
  op_t               head_op;
  check_t            want;

  date_time_check_weekday_top #(.YEAR_SPAN(SPAN)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .stamp(stamp_in),
    .done(done),
    .check(check),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // validity flags, year offset and weekday of one date/time word
  function automatic check_t date_check(stamp_t s, logic [YEAR_W-1:0] base);
    check_t c;
    int     yr;
    int     mo;
    int     dy;
    int     len;
    int     y;
    int     m;
    int     w;
    int     early;
    logic   leap;
    logic   year_ok;
    yr = int'(s.year);
    mo = int'(s.month);
    dy = int'(s.day);
    c = '0;
    c.time_ok = s.hour < HOURS_PER_DAY && s.minute < MINUTES_PER_HOUR &&
                s.second < MINUTES_PER_HOUR;
    year_ok = yr >= int'(base) && yr <= int'(base) + SPAN;
    if (mo >= 1 && mo <= int'(MONTH_DEC)) begin
      case (mo)
        4, 6, 9, 11: len = 30;
        2:           len = 28;
        default:     len = 31;
      endcase
      leap = (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
      if (mo == int'(MONTH_FEB) && leap) len = len + 1;
      c.date_ok = year_ok && dy >= 1 && dy <= len;
      // Jan/Feb count as months 11/12 of the previous year; +400 keeps year 0 positive
      early = (mo <= int'(MONTH_FEB)) ? 1 : 0;
      y = yr + 400 - early;
      m = mo + 12 * early - 2;
      w = (dy + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
      c.weekday = (w == 0) ? SUNDAY : w[WDAY_W-1:0];
    end else begin
      c.weekday = NO_WEEKDAY;
    end
    if (c.date_ok) c.year_offset = OFFSET_W'(yr - int'(base));
    return c;
  endfunction

  function automatic stamp_t rand_stamp(int base);
    stamp_t s;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 70) s.year = YEAR_W'(base - 4 + int'($urandom_range(0, 136)));
    else s.year = YEAR_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80) s.month = FIELD_W'($urandom_range(1, 12));
    else if (r < 90) s.month = FIELD_W'($urandom_range(0, 14));
    else s.month = FIELD_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) s.day = FIELD_W'($urandom_range(1, 31));
    else if (r < 80) s.day = FIELD_W'($urandom_range(27, 32));
    else s.day = FIELD_W'($urandom);
    s.hour = FIELD_W'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 25) : $urandom);
    s.minute = FIELD_W'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 61) : $urandom);
    s.second = FIELD_W'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 61) : $urandom);
    return s;
  endfunction

  // sender idle time after a word: mostly none or short, now and then long,
  // with occasional back-to-back bursts
  function int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_stamp(int y, int mo, int d, int h, int mi, int s);
    op_t op;
    op.kind = OP_STAMP;
    op.stamp.year = YEAR_W'(y);
    op.stamp.month = FIELD_W'(mo);
    op.stamp.day = FIELD_W'(d);
    op.stamp.hour = FIELD_W'(h);
    op.stamp.minute = FIELD_W'(mi);
    op.stamp.second = FIELD_W'(s);
    op.value = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_op(op_kind_t kind, int value);
    op_t op;
    op.kind = kind;
    op.stamp = '0;
    op.value = YEAR_W'(value);
    pending_ops.push_back(op);
  endtask

  task automatic report_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors = errors + 1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_cnt <= 0;
    end else begin
      step_start = start;
      step_we = 1'b0;
      if (start && !busy) step_start = 1'b0;
      if (!step_start) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pending_ops.size() != 0) begin
          head_op = pending_ops[0];
          case (head_op.kind)
            OP_STAMP: begin
              step_start = 1'b1;
              stamp_in <= head_op.stamp;
              void'(pending_ops.pop_front());
              gap_cnt <= pick_gap();
            end
            OP_CFG: begin
              // only with nothing in flight: start low last cycle, no result due
              if (!start && !cfg_we && due_checks.size() == 0) begin
                step_we = 1'b1;
                cfg_wdata <= head_op.value;
                void'(pending_ops.pop_front());
              end
            end
            default: begin
              if (!start && due_checks.size() == 0) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      start <= step_start;
      cfg_we <= step_we;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      model_base = BASE_YEAR_RESET;
    end else begin
      if (start && !busy) due_checks.push_back(date_check(stamp_in, model_base));
      if (done) begin
        if (due_checks.size() == 0) begin
          $display("%0t: result word with none expected, actual %p", $time, check);
          errors = errors + 1;
        end else begin
          want = due_checks.pop_front();
          report_field("date_ok", want.date_ok, check.date_ok);
          report_field("time_ok", want.time_ok, check.time_ok);
          report_field("year_offset", want.year_offset, check.year_offset);
          report_field("weekday", want.weekday, check.weekday);
        end
      end
      if (cfg_we) model_base = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int bases[6];
    int base;
    int p;
    int i;
    // directed, reset base 2000
    add_stamp(2000, 1, 1, 0, 0, 0);
    add_stamp(2127, 12, 31, 23, 59, 59);
    add_stamp(2128, 12, 31, 23, 59, 59);
    add_stamp(1999, 12, 31, 12, 30, 30);
    add_stamp(0, 1, 1, 24, 0, 0);
    add_stamp(0, 2, 28, 0, 60, 0);
    add_stamp(4095, 6, 15, 0, 0, 60);
    add_stamp(2010, 0, 1, 255, 255, 255);
    add_stamp(2010, 13, 1, 10, 10, 10);
    add_stamp(2010, 255, 255, 10, 10, 10);
    add_stamp(2010, 3, 0, 10, 10, 10);
    add_stamp(2010, 3, 32, 10, 10, 10);
    add_stamp(2010, 4, 30, 10, 10, 10);
    add_stamp(2010, 4, 31, 10, 10, 10);
    add_stamp(2000, 2, 29, 5, 5, 5);
    add_stamp(2100, 2, 29, 5, 5, 5);
    add_stamp(2024, 2, 29, 5, 5, 5);
    add_stamp(2023, 2, 29, 5, 5, 5);
    add_stamp(2023, 2, 28, 5, 5, 5);
    add_stamp(2100, 2, 28, 5, 5, 5);
    add_stamp(3000, 7, 4, 5, 5, 5);
    add_op(OP_DRAIN, 0);
    // base 0: year 0 is a leap year and the early-month weekday path
    add_op(OP_CFG, 0);
    add_stamp(0, 1, 1, 0, 0, 0);
    add_stamp(0, 2, 29, 0, 0, 0);
    add_stamp(127, 12, 31, 0, 0, 0);
    add_op(OP_DRAIN, 0);

    bases[0] = 2000;
    bases[1] = 0;
    bases[2] = 3968;
    bases[3] = 1900;
    bases[4] = $urandom_range(0, 3968);
    bases[5] = 2000;
    for (p = 0; p < 6; p++) begin
      base = bases[p];
      add_op(OP_CFG, base);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pending_ops.push_back('{OP_STAMP, rand_stamp(base), '0});
        if ($urandom_range(0, 99) == 0) add_op(OP_DRAIN, 0);
      end
      add_op(OP_DRAIN, 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || start || due_checks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_checks.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, due_checks.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
